>>> hw/rtl/orrs_pkg.sv
// ----------------------------------------------------------------------------
// orrs_pkg
// Shared widths, field positions and the per-word result type of the orbit
// round-robin event splitter.
// ----------------------------------------------------------------------------
package orrs_pkg;

  localparam int WORD_W     = 64;  // stream word
  localparam int COUNT_W    = 12;  // payload word count in header bits 11:0
  localparam int ORBIT_W    = 30;  // orbit number in header bits 53:24
  localparam int ORBIT_LSB  = 24;
  localparam int TOTAL_W    = 32;  // saturating totals
  localparam int CFG_W      = 5;   // sink_count register
  localparam int SINK_OUT_W = 4;   // sink index as shown on the output

  localparam int DEFAULT_MAX_SINKS = 16;

  localparam logic [CFG_W-1:0] SINK_COUNT_RESET = CFG_W'(1);

  // Output payload layout, lowest bit first.
  localparam int TDATA_W = WORD_W + 3 * TOTAL_W;  // 160 bits, whole bytes
  localparam int TUSER_W = SINK_OUT_W + 1;        // sink index, header flag

  typedef struct packed {
    logic [TOTAL_W-1:0]    candidate_total;
    logic [TOTAL_W-1:0]    event_total;
    logic [TOTAL_W-1:0]    orbit_total;
    logic                  end_of_event;
    logic                  is_header;
    logic [SINK_OUT_W-1:0] sink_index;
    logic [WORD_W-1:0]     out_word;
  } result_t;

endpackage

>>> hw/rtl/orbit_round_robin_event_splitter.sv
// ----------------------------------------------------------------------------
// orbit_round_robin_event_splitter
// Splits a 64-bit event stream over round-robin sinks chosen per orbit.
// ----------------------------------------------------------------------------
// Every word that enters on the slave stream leaves on the master stream one
// transaction later, unchanged, tagged with the sink that should receive it,
// a header flag, an end-of-event flag and three saturating 32-bit totals
// (orbit changes, headers and payload words seen so far, this word included).
// Framing comes only from the payload count in header bits 11:0: the first
// word after reset is a header, and after a header with count N the next N
// words are payload. A header whose orbit (bits 53:24) differs from the last
// one moves the sink on by one, wrapping at the configured sink count; the
// first header after reset always goes to sink 0. The block takes one word
// per clock cycle at full rate while the output is not stalled. Each word
// passes through the input register and then the result register, with
// the framing and sink decision between them.
// The sink count is written through the configuration channel, which is
// always ready, and should only be changed while no word is in flight.
// ----------------------------------------------------------------------------
module orbit_round_robin_event_splitter
  import orrs_pkg::*;
#(
  parameter int MAX_SINKS = DEFAULT_MAX_SINKS
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration channel: sink_count
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data,
  // Slave stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [WORD_W-1:0]  s_axis_tdata,   // [63:0] stream_word
  // Master stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [63:0] out_word, [95:64] orbit_total,
                                             // [127:96] event_total,
                                             // [159:128] candidate_total
  output logic               m_axis_tlast,   // end_of_event
  output logic [TUSER_W-1:0] m_axis_tuser    // [3:0] sink_index, [4] is_header
);

  logic [CFG_W-1:0]  sink_count;

  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              out_valid;
  result_t           out_res;
  result_t           result;

  logic              out_free;
  logic              advance;

  // The configuration register is always ready to take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sink_count <= SINK_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sink_count <= cfg_data;
    end
  end

  // The result register can take a new word when it is empty or being
  // drained in this cycle; the word in the input register then moves on and
  // the tracker commits its state for that word.
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word <= s_axis_tdata;
    end
  end

  orrs_tracker #(
    .MAX_SINKS (MAX_SINKS)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .word       (in_word),
    .advance    (advance),
    .sink_count (sink_count),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.candidate_total, out_res.event_total,
                          out_res.orbit_total, out_res.out_word};
  assign m_axis_tlast  = out_res.end_of_event;
  assign m_axis_tuser  = {out_res.is_header, out_res.sink_index};

endmodule

>>> hw/rtl/orrs_tracker.sv
// ----------------------------------------------------------------------------
// orrs_tracker
// Event framing, orbit tracking, round-robin sink selection and saturating
// totals. Works out the result for the word in the input register and
// updates its state when that word moves on.
// ----------------------------------------------------------------------------
module orrs_tracker
  import orrs_pkg::*;
#(
  parameter int MAX_SINKS = DEFAULT_MAX_SINKS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] word,
  input  logic              advance,
  input  logic [CFG_W-1:0]  sink_count,
  output result_t           result
);

  // The register is CFG_W bits, so the usable count never exceeds its maximum.
  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int EFF_MAX = (MAX_SINKS < CFG_MAX) ? MAX_SINKS : CFG_MAX;
  localparam int SINK_W  = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;

  logic [COUNT_W-1:0] payload_left, payload_left_next;
  logic [ORBIT_W-1:0] previous_orbit, previous_orbit_next;
  logic               orbit_seen, orbit_seen_next;
  logic [SINK_W-1:0]  current_sink, current_sink_next;
  logic [TOTAL_W-1:0] orbit_counter, orbit_counter_next;
  logic [TOTAL_W-1:0] event_counter, event_counter_next;
  logic [TOTAL_W-1:0] candidate_counter, candidate_counter_next;

  logic               is_header;
  logic               orbit_change;
  logic [ORBIT_W-1:0] orbit;
  logic [COUNT_W-1:0] count;
  logic [CFG_W-1:0]   eff_sinks;
  logic [SINK_W:0]    sink_inc;
  logic [SINK_W-1:0]  sink_step;
  logic               end_of_event;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    return (&v) ? v : v + TOTAL_W'(1);
  endfunction

  assign is_header    = (payload_left == '0);
  assign orbit        = word[ORBIT_LSB +: ORBIT_W];
  assign count        = word[COUNT_W-1:0];
  assign orbit_change = is_header && (!orbit_seen || (orbit != previous_orbit));

  // A count of zero acts as one; a count above the limit is clamped to it.
  assign eff_sinks = (sink_count == '0)              ? CFG_W'(1) :
                     (sink_count > CFG_W'(EFF_MAX)) ? CFG_W'(EFF_MAX) : sink_count;

  assign sink_inc  = {1'b0, current_sink} + (SINK_W+1)'(1);
  assign sink_step = (CFG_W'(sink_inc) >= eff_sinks) ? '0 : SINK_W'(sink_inc);

  always_comb begin
    payload_left_next      = payload_left;
    previous_orbit_next    = previous_orbit;
    orbit_seen_next        = orbit_seen;
    current_sink_next      = current_sink;
    orbit_counter_next     = orbit_counter;
    event_counter_next     = event_counter;
    candidate_counter_next = candidate_counter;
    if (is_header) begin
      if (orbit_change) begin
        current_sink_next   = orbit_seen ? sink_step : '0;
        orbit_counter_next  = sat_inc(orbit_counter);
        previous_orbit_next = orbit;
        orbit_seen_next     = 1'b1;
      end
      event_counter_next = sat_inc(event_counter);
      payload_left_next  = count;
      end_of_event       = (count == '0);
    end else begin
      candidate_counter_next = sat_inc(candidate_counter);
      payload_left_next      = payload_left - COUNT_W'(1);
      end_of_event           = (payload_left == COUNT_W'(1));
    end
  end

  always_comb begin
    result.out_word        = word;
    result.sink_index      = SINK_OUT_W'(current_sink_next);
    result.is_header       = is_header;
    result.end_of_event    = end_of_event;
    result.orbit_total     = orbit_counter_next;
    result.event_total     = event_counter_next;
    result.candidate_total = candidate_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_left      <= '0;
      previous_orbit    <= '0;
      orbit_seen        <= 1'b0;
      current_sink      <= '0;
      orbit_counter     <= '0;
      event_counter     <= '0;
      candidate_counter <= '0;
    end else if (advance) begin
      payload_left      <= payload_left_next;
      previous_orbit    <= previous_orbit_next;
      orbit_seen        <= orbit_seen_next;
      current_sink      <= current_sink_next;
      orbit_counter     <= orbit_counter_next;
      event_counter     <= event_counter_next;
      candidate_counter <= candidate_counter_next;
    end
  end

endmodule

>>> hw/rtl/orrs_checker.sv
// ----------------------------------------------------------------------------
// orrs_checker
// Port-level checks for the orbit round-robin event splitter, bound to the
// top level.
// ----------------------------------------------------------------------------
module orrs_checker
  import orrs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast,
  input logic [TUSER_W-1:0] m_axis_tuser
);

  localparam int HDR_BIT = SINK_OUT_W;

  // No output transaction is offered straight after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled output transaction keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

  // With the output stage empty the input is never held off.
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input held off with an empty output stage");

  // A header ends its event exactly when its payload count is zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[HDR_BIT] |->
      (m_axis_tlast == (m_axis_tdata[COUNT_W-1:0] == '0)))
    else $error("header end-of-event flag disagrees with payload count");

  // A header has been counted, and so has at least one orbit.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[HDR_BIT] |->
      (m_axis_tdata[WORD_W+TOTAL_W +: TOTAL_W] != '0)
      && (m_axis_tdata[WORD_W +: TOTAL_W] != '0))
    else $error("header shown with a zero event or orbit total");

endmodule

bind orbit_round_robin_event_splitter orrs_checker u_orrs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the orbit round-robin event splitter.
// ----------------------------------------------------------------------------
// A driver feeds stream words from a queue of pending words. Every accepted
// word is run through a local predictor of the framing, sink and total
// logic, and the prediction is queued. A monitor compares each output
// transaction field by field with the oldest prediction. The run starts with
// a short directed sequence. It then goes through phases of random,
// well-formed events. Each phase writes a sink count and uses one of four
// patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import orrs_pkg::*;

  localparam int MAX_SINKS_TB = DEFAULT_MAX_SINKS;
  localparam int DRAIN_CYCLES = 6;     // drain margin after the queues empty
  localparam int LONG_HOLD    = 300;   // receiver back-pressure stretch
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all

  // One predicted output transaction.
  typedef struct packed {
    logic [WORD_W-1:0]     word;
    logic [SINK_OUT_W-1:0] sink;
    logic                  head;
    logic                  tail;
    logic [TOTAL_W-1:0]    orbits;
    logic [TOTAL_W-1:0]    events;
    logic [TOTAL_W-1:0]    payloads;
  } split_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [WORD_W-1:0]  s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic [TUSER_W-1:0] m_axis_tuser;

  // Stimulus and prediction stores.
  logic [WORD_W-1:0] pending_words[$];
  split_t            pending_results[$];
  int                error_count = 0;
  int                words_queued = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_trigger = 0;
  logic [ORBIT_W-1:0] gen_orbit = '0;

  // Predictor state.
  logic [CFG_W-1:0]   sink_cfg = SINK_COUNT_RESET;
  logic [COUNT_W-1:0] frame_left = '0;
  logic [ORBIT_W-1:0] last_orbit = '0;
  logic               orbit_known = 1'b0;
  int                 sink_now = 0;
  logic [TOTAL_W-1:0] orbit_tally = '0;
  logic [TOTAL_W-1:0] event_tally = '0;
  logic [TOTAL_W-1:0] payload_tally = '0;

  always #4 clk = ~clk;

  orbit_round_robin_event_splitter #(
    .MAX_SINKS(MAX_SINKS_TB)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // Works out the output for one accepted word and moves the predictor on.
  // Framing follows the payload count alone; a header whose orbit differs
  // from the last one, or the very first header, picks the sink.
  function automatic split_t predict_split(logic [WORD_W-1:0] w);
    split_t             r;
    logic [ORBIT_W-1:0] orbit;
    int                 eff;
    int                 nxt;
    r = '0;
    r.word = w;
    if (frame_left == '0) begin
      orbit = w[ORBIT_LSB +: ORBIT_W];
      // A zero count acts as one sink; counts past the limit are clamped.
      eff = (sink_cfg == '0) ? 1 : int'(sink_cfg);
      if (eff > MAX_SINKS_TB) begin
        eff = MAX_SINKS_TB;
      end
      if (!orbit_known || orbit != last_orbit) begin
        nxt = 0;
        if (orbit_known) begin
          // Increment first, then wrap: this also covers an index left
          // beyond a count that has since been lowered.
          nxt = sink_now + 1;
          if (nxt >= eff) begin
            nxt = 0;
          end
        end
        sink_now = nxt;
        orbit_tally = (orbit_tally == '1) ? orbit_tally : orbit_tally + 1'b1;
        last_orbit = orbit;
        orbit_known = 1'b1;
      end
      event_tally = (event_tally == '1) ? event_tally : event_tally + 1'b1;
      frame_left = w[COUNT_W-1:0];
      r.head = 1'b1;
      r.tail = (frame_left == '0);
    end else begin
      payload_tally = (payload_tally == '1) ? payload_tally : payload_tally + 1'b1;
      frame_left = frame_left - 1'b1;
      r.tail = (frame_left == '0);
    end
    r.sink = sink_now[SINK_OUT_W-1:0];
    r.orbits = orbit_tally;
    r.events = event_tally;
    r.payloads = payload_tally;
    return r;
  endfunction

  function automatic void check_field(string what, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  function automatic logic [WORD_W-1:0] header_word(logic [9:0] hi,
      logic [ORBIT_W-1:0] orbit, logic [11:0] mid, logic [COUNT_W-1:0] n);
    return {hi, orbit, mid, n};
  endfunction

  // Queues one whole event: a header with random spare bits, then n random
  // payload words.
  task automatic queue_event(logic [ORBIT_W-1:0] orbit, logic [COUNT_W-1:0] n);
    logic [9:0]  hi;
    logic [11:0] mid;
    hi = 10'($urandom);
    mid = 12'($urandom);
    pending_words.push_back(header_word(hi, orbit, mid, n));
    for (int i = 0; i < n; i++) begin
      pending_words.push_back({$urandom, $urandom});
    end
    words_queued += n + 1;
  endtask

  // Random events until the phase has its share of words. Orbits repeat,
  // step on by one or jump anywhere, so sinks both hold and advance.
  task automatic queue_random_events(int target);
    int                 pick;
    logic [COUNT_W-1:0] n;
    words_queued = 0;
    while (words_queued < target) begin
      pick = $urandom_range(99);
      if (pick >= 40 && pick < 80) begin
        gen_orbit = gen_orbit + 1'b1;
      end else if (pick >= 80) begin
        gen_orbit = ORBIT_W'($urandom);
      end
      if ($urandom_range(99) < 85) begin
        n = COUNT_W'($urandom_range(6));
      end else begin
        n = COUNT_W'($urandom_range(48, 7));
      end
      queue_event(gen_orbit, n);
    end
  endtask

  // The sink count may only change with nothing in flight.
  task automatic write_sink_count(logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    sink_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || s_axis_tvalid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: offers the next pending word once the current one is taken, with
  // random gaps. Each accepted transaction is predicted on the spot.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(predict_split(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transaction against the oldest prediction
  // and drives ready, with random stalls and, on request, one long hold-off.
  always @(posedge clk) begin : monitor_proc
    split_t want;
    int     hold_seen;
    int     hold_left;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unpredicted result, expected nothing, got word %h",
                   $time, m_axis_tdata[63:0]);
        end else begin
          want = pending_results.pop_front();
          check_field("out_word", want.word, m_axis_tdata[63:0]);
          check_field("sink_index", WORD_W'(want.sink), WORD_W'(m_axis_tuser[3:0]));
          check_field("is_header", WORD_W'(want.head), WORD_W'(m_axis_tuser[4]));
          check_field("end_of_event", WORD_W'(want.tail), WORD_W'(m_axis_tlast));
          check_field("orbit_total", WORD_W'(want.orbits),
                      WORD_W'(m_axis_tdata[95:64]));
          check_field("event_total", WORD_W'(want.events),
                      WORD_W'(m_axis_tdata[127:96]));
          check_field("candidate_total", WORD_W'(want.payloads),
                      WORD_W'(m_axis_tdata[159:128]));
        end
      end
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a long run of cycles without any transaction means a hang.
  always @(posedge clk) begin : watchdog_proc
    int quiet;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] sink_plan[8];
    sink_plan = '{5'd0, 5'd16, 5'd31, 5'd17, 5'd2, 5'd1, 5'd3, 5'd0};
    sink_plan[7] = CFG_W'($urandom_range(31));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part with four sinks.
    write_sink_count(5'd4);
    // First header after reset with orbit zero still selects sink 0 and
    // counts as an orbit change; a zero count ends the event on the header.
    pending_words.push_back(header_word(10'h000, '0, 12'h000, 12'd0));
    // Same orbit again: the sink holds.
    pending_words.push_back(header_word(10'h000, '0, 12'h000, 12'd1));
    pending_words.push_back('1);
    // All spare bits and the top orbit set.
    pending_words.push_back(header_word(10'h3FF, '1, 12'hFFF, 12'd2));
    pending_words.push_back('0);
    pending_words.push_back('1);
    pending_words.push_back(header_word(10'h000, 30'd1, 12'h000, 12'd0));
    // A payload word that looks like a header is still payload.
    pending_words.push_back(header_word(10'h000, 30'd2, 12'h000, 12'd1));
    pending_words.push_back(header_word(10'h3FF, 30'd9, 12'hFFF, 12'd0));
    // Fifth orbit change (fourth step on) with four sinks wraps back to sink 0.
    pending_words.push_back(header_word(10'h155, 30'd3, 12'hAAA, 12'd3));
    for (int i = 0; i < 3; i++) begin
      pending_words.push_back({$urandom, $urandom});
    end
    pending_words.push_back(header_word(10'h2AA, 30'd3, 12'h555, 12'd0));
    pending_words.push_back(header_word(10'h000, 30'h2AAAAAAA, 12'h000, 12'd0));
    gen_orbit = 30'h2AAAAAAA;
    wait_drained();

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct = 31;
        end
      endcase
      write_sink_count(sink_plan[p]);
      if (p == 4) begin
        // Hold the output off while the sender keeps offering, so the
        // block fills up and back-pressures its input.
        hold_trigger++;
        queue_random_events(300);
      end else begin
        queue_random_events(80);
      end
      if (p == 6) begin
        // One event with a payload count well past 255 words.
        queue_event(gen_orbit + 1'b1, 12'd300);
      end
      wait_drained();
    end

    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d predicted results never arrived", $time,
               pending_results.size());
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/orrs_pkg.sv
hw/rtl/orrs_tracker.sv
hw/rtl/orbit_round_robin_event_splitter.sv
hw/rtl/orrs_checker.sv
sim/tb.sv
